// ===== hw/rtl/psrl_pkg.sv =====
// Package for the per-source rate limiter: sizes, payload structs, verdict codes,
// configuration register indexes and the sequencer state type.
// No dependencies; every other file in hw/rtl refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package psrl_pkg;

    // Number of tracked sources.
    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // Decoupling queues on either side of the scanner.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    localparam int ADDR_W   = 32;
    localparam int TIME_W   = 32;
    localparam int WINDOW_W = 16;
    localparam int COUNT_W  = 8;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd5;
    localparam logic [COUNT_W-1:0]  MAX_RESET    = 8'd3;
    localparam logic [COUNT_W-1:0]  COUNT_SAT    = 8'hFF;
    localparam logic [COUNT_W-1:0]  COUNT_ONE    = 8'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_SECONDS = 1'b0,
        CFG_MAX_COUNT      = 1'b1
    } t_cfg_index;

    typedef enum logic [2:0] {
        VERDICT_REJECTED  = 3'd0,
        VERDICT_COUNTED   = 3'd1,
        VERDICT_RESTARTED = 3'd2,
        VERDICT_NEW       = 3'd3,
        VERDICT_FULL      = 3'd4
    } t_verdict;

    typedef struct packed {
        logic [ADDR_W-1:0] source_address;
        logic [TIME_W-1:0] now_seconds;
    } t_in;

    typedef struct packed {
        logic     allowed;
        t_verdict verdict;
    } t_out;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EVAL
    } t_back_state;

endpackage

`default_nettype wire

// ===== hw/rtl/psrl_front.sv =====
// Front end of the rate limiter: a short request queue that takes connection
// attempts from the push/full side and hands them to the table scanner.
// Depends on psrl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psrl_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         push,
    output logic              full,
    input  psrl_pkg::t_in     i_attempt,
    output logic              o_item_valid,
    input  wire logic         i_item_ready,
    output psrl_pkg::t_in     o_item
);

    psrl_pkg::t_in                     r_mem [psrl_pkg::QDEPTH];
    logic [psrl_pkg::QPTR_W-1:0]       r_wp;
    logic [psrl_pkg::QPTR_W-1:0]       r_rp;
    logic [psrl_pkg::QCNT_W-1:0]       r_cnt;
    logic                              w_wr;
    logic                              w_rd;

    assign full         = (r_cnt == psrl_pkg::QCNT_W'(psrl_pkg::QDEPTH));
    assign o_item_valid = (r_cnt != '0);
    assign o_item       = r_mem[r_rp];
    assign w_wr         = push && !full;
    assign w_rd         = o_item_valid && i_item_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_attempt;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/psrl_back.sv =====
// Back end of the rate limiter: configuration registers, the source table and
// the sequencer that scans it one slot a cycle and then applies the update.
// Depends on psrl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psrl_back (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  psrl_pkg::t_cfg_index                 i_cfg_index,
    input  wire logic [psrl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_item_valid,
    output logic                                 o_item_ready,
    input  psrl_pkg::t_in                        i_item,
    output logic                                 o_res_valid,
    input  wire logic                            i_res_ready,
    output psrl_pkg::t_out                       o_res
);

    psrl_pkg::t_back_state                  r_state;
    psrl_pkg::t_back_state                  n_state;
    logic [psrl_pkg::IDX_W-1:0]             r_idx;
    logic [psrl_pkg::IDX_W-1:0]             n_idx;

    logic [psrl_pkg::WINDOW_W-1:0]          r_window;
    logic [psrl_pkg::COUNT_W-1:0]           r_max;

    logic [psrl_pkg::ENTRIES-1:0]           r_valid;
    logic [psrl_pkg::ADDR_W-1:0]            r_addr  [psrl_pkg::ENTRIES];
    logic [psrl_pkg::TIME_W-1:0]            r_start [psrl_pkg::ENTRIES];
    logic [psrl_pkg::COUNT_W-1:0]           r_count [psrl_pkg::ENTRIES];

    psrl_pkg::t_in                          r_item;
    logic                                   r_hit;
    logic                                   r_free;
    logic [psrl_pkg::IDX_W-1:0]             r_hit_idx;
    logic [psrl_pkg::IDX_W-1:0]             r_free_idx;
    logic [psrl_pkg::TIME_W-1:0]            r_hit_start;
    logic [psrl_pkg::COUNT_W-1:0]           r_hit_count;

    logic                                   w_take;
    logic                                   w_done;
    logic                                   w_last;
    logic                                   w_match;
    logic [psrl_pkg::TIME_W-1:0]            w_elapsed;
    logic                                   w_in_window;
    logic [psrl_pkg::COUNT_W-1:0]           w_count_inc;
    logic                                   w_reject;

    assign o_cfg_ready = 1'b1;
    assign w_last      = (r_idx == psrl_pkg::IDX_W'(psrl_pkg::ENTRIES - 1));
    assign w_match     = r_valid[r_idx] && (r_addr[r_idx] == r_item.source_address);

    // Decision for the slot found by the scan.
    assign w_elapsed   = r_item.now_seconds - r_hit_start;
    assign w_in_window = (w_elapsed < psrl_pkg::TIME_W'(r_window));
    assign w_count_inc = (r_hit_count == psrl_pkg::COUNT_SAT) ? r_hit_count
                                                               : r_hit_count + 1'b1;
    assign w_reject    = (w_count_inc > r_max);

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        o_item_ready = 1'b0;
        o_res_valid  = 1'b0;
        o_res        = '{allowed: 1'b1, verdict: psrl_pkg::VERDICT_FULL};
        case (r_state)
            psrl_pkg::ST_IDLE: begin
                o_item_ready = 1'b1;
                if (i_item_valid) begin
                    n_state = psrl_pkg::ST_SCAN;
                    n_idx   = '0;
                end
            end
            psrl_pkg::ST_SCAN: begin
                if (w_last) begin
                    n_state = psrl_pkg::ST_EVAL;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            psrl_pkg::ST_EVAL: begin
                o_res_valid = 1'b1;
                if (r_hit) begin
                    if (!w_in_window) begin
                        o_res.verdict = psrl_pkg::VERDICT_RESTARTED;
                    end else if (w_reject) begin
                        o_res.allowed = 1'b0;
                        o_res.verdict = psrl_pkg::VERDICT_REJECTED;
                    end else begin
                        o_res.verdict = psrl_pkg::VERDICT_COUNTED;
                    end
                end else if (r_free) begin
                    o_res.verdict = psrl_pkg::VERDICT_NEW;
                end
                if (i_res_ready) begin
                    n_state = psrl_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = psrl_pkg::ST_IDLE;
            end
        endcase
    end

    assign w_take = (r_state == psrl_pkg::ST_IDLE) && i_item_valid;
    assign w_done = (r_state == psrl_pkg::ST_EVAL) && i_res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= psrl_pkg::ST_IDLE;
            r_idx    <= '0;
            r_window <= psrl_pkg::WINDOW_RESET;
            r_max    <= psrl_pkg::MAX_RESET;
            r_valid  <= '0;
            r_hit    <= 1'b0;
            r_free   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    psrl_pkg::CFG_WINDOW_SECONDS: r_window <= i_cfg_data;
                    psrl_pkg::CFG_MAX_COUNT:      r_max    <= i_cfg_data[psrl_pkg::COUNT_W-1:0];
                    default:                      r_max    <= r_max;
                endcase
            end
            if (w_take) begin
                r_hit  <= 1'b0;
                r_free <= 1'b0;
            end else if (r_state == psrl_pkg::ST_SCAN) begin
                if (!r_hit && w_match) begin
                    r_hit <= 1'b1;
                end
                if (!r_free && !r_valid[r_idx]) begin
                    r_free <= 1'b1;
                end
            end
            if (w_done && !r_hit && r_free) begin
                r_valid[r_free_idx] <= 1'b1;
            end
        end
    end

    // Scan captures and table writes; payload only, no reset needed.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item <= i_item;
        end
        if (r_state == psrl_pkg::ST_SCAN) begin
            if (!r_hit && w_match) begin
                r_hit_idx   <= r_idx;
                r_hit_start <= r_start[r_idx];
                r_hit_count <= r_count[r_idx];
            end
            if (!r_free && !r_valid[r_idx]) begin
                r_free_idx <= r_idx;
            end
        end
        if (w_done) begin
            if (r_hit) begin
                if (w_in_window) begin
                    r_count[r_hit_idx] <= w_count_inc;
                end else begin
                    r_start[r_hit_idx] <= r_item.now_seconds;
                    r_count[r_hit_idx] <= psrl_pkg::COUNT_ONE;
                end
            end else if (r_free) begin
                r_addr[r_free_idx]  <= r_item.source_address;
                r_start[r_free_idx] <= r_item.now_seconds;
                r_count[r_free_idx] <= psrl_pkg::COUNT_ONE;
            end
        end
    end

    // A new source occupies exactly one more slot.
    a_new_fills_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_done && !r_hit && r_free) |=>
            ($countones(r_valid) == $past($countones(r_valid)) + 1))
        else $error("new entry did not take exactly one slot");

    // The table-full verdict is only given when every slot is in use.
    a_full_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.verdict == psrl_pkg::VERDICT_FULL) |-> (&r_valid))
        else $error("table-full verdict with a free slot");

    // A found slot is a valid one that holds the requesting address.
    a_hit_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == psrl_pkg::ST_EVAL && r_hit) |->
            (r_valid[r_hit_idx] && r_addr[r_hit_idx] == r_item.source_address))
        else $error("matched slot does not hold the source");

    // The table only changes on completion of a request.
    a_valid_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_done |=> $stable(r_valid))
        else $error("slot occupancy changed outside completion");

endmodule

`default_nettype wire

// ===== hw/rtl/psrl_resq.sv =====
// Result queue of the rate limiter: holds verdicts from the scanner until they
// are taken on the empty/pop side.
// Depends on psrl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psrl_resq (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_res_valid,
    output logic              o_res_ready,
    input  psrl_pkg::t_out    i_res,
    output logic              empty,
    input  wire logic         pop,
    output psrl_pkg::t_out    o_result
);

    psrl_pkg::t_out                    r_mem [psrl_pkg::QDEPTH];
    logic [psrl_pkg::QPTR_W-1:0]       r_wp;
    logic [psrl_pkg::QPTR_W-1:0]       r_rp;
    logic [psrl_pkg::QCNT_W-1:0]       r_cnt;
    logic                              w_wr;
    logic                              w_rd;

    assign o_res_ready = (r_cnt != psrl_pkg::QCNT_W'(psrl_pkg::QDEPTH));
    assign empty       = (r_cnt == '0);
    assign o_result    = r_mem[r_rp];
    assign w_wr        = i_res_valid && o_res_ready;
    assign w_rd        = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_res;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/per_source_rate_limiter_core.sv =====
// Per-source fixed-window rate limiter. Each request carries a source address and
// the current time in seconds; each produces one result: allowed plus a verdict
// (rejected, counted in window, window restarted, new entry, table full). The
// source table holds psrl_pkg::ENTRIES slots and is scanned one slot per clock.
// One request is in the scanner at a time; two-deep queues on the request and
// result sides let both neighbors run independently of the scan. The table is
// empty after reset with no clearing pass. Configuration registers (window
// length, maximum count) are written through the cfg channel, always ready, and
// should only be written while no request is outstanding.
// Depends on psrl_pkg, psrl_front, psrl_back and psrl_resq.
`timescale 1ns / 1ps
`default_nettype none

module per_source_rate_limiter_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            push,
    output logic                                 full,
    input  psrl_pkg::t_in                        i_attempt,
    output logic                                 empty,
    input  wire logic                            pop,
    output psrl_pkg::t_out                       o_result,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  psrl_pkg::t_cfg_index                 i_cfg_index,
    input  wire logic [psrl_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic           w_item_valid;
    logic           w_item_ready;
    psrl_pkg::t_in  w_item;
    logic           w_res_valid;
    logic           w_res_ready;
    psrl_pkg::t_out w_res;

    psrl_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_attempt    (i_attempt),
        .o_item_valid (w_item_valid),
        .i_item_ready (w_item_ready),
        .o_item       (w_item)
    );

    psrl_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_item_valid (w_item_valid),
        .o_item_ready (w_item_ready),
        .i_item       (w_item),
        .o_res_valid  (w_res_valid),
        .i_res_ready  (w_res_ready),
        .o_res        (w_res)
    );

    psrl_resq u_resq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (w_res_valid),
        .o_res_ready (w_res_ready),
        .i_res       (w_res),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result)
    );

endmodule

`default_nettype wire

// ===== tb/psrl_verdict_checker.sv =====
// Checker for the per-source rate limiter: keeps its own copy of the source table
// and configuration, predicts allowed and verdict for every accepted request and
// compares them with the results popped from the block. Depends on psrl_pkg.
`timescale 1ns / 1ps

module psrl_verdict_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_push,
    input  wire logic                            i_full,
    input  psrl_pkg::t_in                        i_attempt,
    input  wire logic                            i_empty,
    input  wire logic                            i_pop,
    input  psrl_pkg::t_out                       i_result,
    input  wire logic                            i_cfg_valid,
    input  wire logic                            i_cfg_ready,
    input  psrl_pkg::t_cfg_index                 i_cfg_index,
    input  wire logic [psrl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                                   o_pending,
    output int                                   o_failures
);
    import psrl_pkg::*;

    logic [WINDOW_W-1:0] window_len;
    logic [COUNT_W-1:0]  count_limit;
    logic                slot_used  [ENTRIES];
    logic [ADDR_W-1:0]   slot_addr  [ENTRIES];
    logic [TIME_W-1:0]   slot_start [ENTRIES];
    logic [COUNT_W-1:0]  slot_count [ENTRIES];
    t_out                verdict_q  [$];
    int                  fail_count = 0;

    // Looks the source up, updates the table copy and returns the verdict.
    function automatic t_out score_attempt(input t_in a);
        t_out             r;
        int               hit;
        int               free_slot;
        logic [TIME_W-1:0] elapsed;
        hit = -1;
        free_slot = -1;
        r.allowed = 1'b1;
        r.verdict = VERDICT_FULL;
        for (int k = 0; k < ENTRIES; k++) begin
            if (slot_used[k]) begin
                if (hit < 0 && slot_addr[k] == a.source_address)
                    hit = k;
            end else if (free_slot < 0) begin
                free_slot = k;
            end
        end
        if (hit >= 0) begin
            // Elapsed time wraps, so a clock running backwards looks like a long gap.
            elapsed = a.now_seconds - slot_start[hit];
            if (elapsed < {16'd0, window_len}) begin
                if (slot_count[hit] != COUNT_SAT)
                    slot_count[hit] = slot_count[hit] + 1'b1;
                if (slot_count[hit] > count_limit) begin
                    r.allowed = 1'b0;
                    r.verdict = VERDICT_REJECTED;
                end else begin
                    r.verdict = VERDICT_COUNTED;
                end
            end else begin
                slot_start[hit] = a.now_seconds;
                slot_count[hit] = COUNT_ONE;
                r.verdict = VERDICT_RESTARTED;
            end
        end else if (free_slot >= 0) begin
            slot_used[free_slot]  = 1'b1;
            slot_addr[free_slot]  = a.source_address;
            slot_start[free_slot] = a.now_seconds;
            slot_count[free_slot] = COUNT_ONE;
            r.verdict = VERDICT_NEW;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            window_len = WINDOW_RESET;
            count_limit = MAX_RESET;
            for (int k = 0; k < ENTRIES; k++) begin
                slot_used[k]  = 1'b0;
                slot_addr[k]  = '0;
                slot_start[k] = '0;
                slot_count[k] = '0;
            end
            verdict_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_WINDOW_SECONDS: window_len = i_cfg_data[WINDOW_W-1:0];
                    CFG_MAX_COUNT:      count_limit = i_cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end
            // The pop is handled first: a result can never belong to a request
            // accepted at the same edge.
            if (i_pop && !i_empty) begin
                if (verdict_q.size() == 0) begin
                    $display("%0t: result with no request waiting, expected none, got %0d/%0d",
                             $time, i_result.allowed, i_result.verdict);
                    fail_count++;
                end else begin
                    want = verdict_q.pop_front();
                    if (i_result.allowed !== want.allowed) begin
                        $display("%0t: allowed mismatch, expected %0d, got %0d",
                                 $time, want.allowed, i_result.allowed);
                        fail_count++;
                    end
                    if (i_result.verdict !== want.verdict) begin
                        $display("%0t: verdict mismatch, expected %0d, got %0d",
                                 $time, want.verdict, i_result.verdict);
                        fail_count++;
                    end
                end
            end
            if (i_push && !i_full)
                verdict_q.push_back(score_attempt(i_attempt));
        end
        o_pending <= verdict_q.size();
        o_failures <= fail_count;
    end

endmodule

// ===== tb/tb_per_source_rate_limiter_core.sv =====
// Top of the rate limiter testbench: clock, reset, request and configuration
// stimulus, random pop stalls, watchdog and verdict. Depends on psrl_pkg,
// per_source_rate_limiter_core and psrl_verdict_checker.
`timescale 1ns / 1ps

module tb_per_source_rate_limiter_core;
    import psrl_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TAIL_CYCLES    = 4 * (ENTRIES + 2);

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  push = 1'b0;
    t_in                   i_attempt = '0;
    logic                  pop = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    t_cfg_index            i_cfg_index = CFG_WINDOW_SECONDS;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  full;
    logic                  empty;
    logic                  o_cfg_ready;
    t_out                  o_result;

    int                    results_pending;
    int                    check_failures;
    int                    send_idle_pct = 0;
    int                    recv_stall_pct = 0;
    int                    quiet_cycles = 0;
    logic [ADDR_W-1:0]     source_pool [ENTRIES];
    logic [TIME_W-1:0]     now_s = '0;
    logic [WINDOW_W-1:0]   window_cur = WINDOW_RESET;

    per_source_rate_limiter_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_attempt   (i_attempt),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    psrl_verdict_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_full      (full),
        .i_attempt   (i_attempt),
        .i_empty     (empty),
        .i_pop       (pop),
        .i_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_pending   (results_pending),
        .o_failures  (check_failures)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("tb_per_source_rate_limiter_core NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Leaves push high after the handshake so back-to-back requests need no gap.
    task automatic send_attempt(input logic [ADDR_W-1:0] addr, input logic [TIME_W-1:0] t);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_attempt.source_address <= addr;
        i_attempt.now_seconds <= t;
        do @(posedge i_clk); while (full);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        @(posedge i_clk);
        while (results_pending != 0) @(posedge i_clk);
    endtask

    // Both registers in one burst so valid stays high between the two writes.
    task automatic write_config(input logic [WINDOW_W-1:0] win, input logic [COUNT_W-1:0] maxc);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_WINDOW_SECONDS;
        i_cfg_data <= win;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CFG_MAX_COUNT;
        i_cfg_data <= CFG_DATA_W'(maxc);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        window_cur = win;
    endtask

    // Most requests come from tracked sources; the rest are unknown sources that
    // find the table full. A calm phase keeps time almost still so one source
    // can pile up enough attempts to saturate its count.
    task automatic run_random(input int n_items, input int hot_pct, input bit calm,
                              input int pause_at);
        logic [ADDR_W-1:0] addr;
        int                r;
        for (int k = 0; k < n_items; k++) begin
            if (k == pause_at)
                wait_drained();
            r = $urandom_range(99);
            if (r < hot_pct)
                addr = source_pool[2];
            else if (r < hot_pct + (100 - hot_pct) * 8 / 10)
                addr = source_pool[$urandom_range(ENTRIES - 1)];
            else if (r < hot_pct + (100 - hot_pct) * 9 / 10)
                addr = $urandom;
            else
                addr = source_pool[$urandom_range(ENTRIES - 1)] ^ (32'd1 << $urandom_range(31));
            r = $urandom_range(99);
            if (calm) begin
                if (r >= 50)
                    now_s = now_s + 1'b1;
            end else if (r >= 45) begin
                if (r < 80)
                    now_s = now_s + $urandom_range(1, window_cur / 4 + 1);
                else if (r < 92)
                    now_s = now_s + $urandom_range(window_cur - 1, window_cur + 1);
                else if (r < 96)
                    now_s = now_s - $urandom_range(1, 1000);
                else
                    now_s = $urandom;
            end
            send_attempt(addr, now_s);
        end
    endtask

    initial begin
        source_pool[0] = 32'h0000_0000;
        source_pool[1] = 32'hFFFF_FFFF;
        source_pool[2] = 32'hA5A5_A5A5;
        source_pool[3] = 32'h5A5A_5A5A;
        for (int k = 4; k < ENTRIES; k++)
            source_pool[k] = $urandom;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Address zero is tracked like any other source; default window 5, limit 3.
        send_attempt(source_pool[0], 32'd0);
        send_attempt(source_pool[0], 32'd0);
        send_attempt(source_pool[0], 32'd1);
        send_attempt(source_pool[0], 32'd2);
        send_attempt(source_pool[0], 32'd4);
        send_attempt(source_pool[0], 32'd5);
        // Elapsed time wrapping past zero, then time running backwards.
        send_attempt(source_pool[1], 32'hFFFF_FFFF);
        send_attempt(source_pool[1], 32'd3);
        send_attempt(source_pool[1], 32'd2);
        for (int k = 2; k < ENTRIES; k++)
            send_attempt(source_pool[k], 32'h8000_0000 + k);
        // Table is full now: an unknown source is admitted untracked.
        send_attempt(32'h1357_9BDF, 32'h8000_0000);
        send_attempt(source_pool[ENTRIES - 1], 32'h8000_0000 + ENTRIES - 1);
        wait_drained();

        now_s = 32'h8000_1000;
        write_config(16'd1, 8'd1);
        run_random(90, 10, 1'b0, -1);

        wait_drained();
        send_idle_pct = 51;
        write_config(16'hFFFF, 8'd254);
        run_random(300, 95, 1'b1, -1);

        wait_drained();
        send_idle_pct = 0;
        recv_stall_pct = 51;
        write_config(16'd10, 8'd2);
        run_random(90, 10, 1'b0, -1);

        wait_drained();
        send_idle_pct = 12;
        recv_stall_pct = 12;
        write_config(16'd300, 8'd20);
        run_random(90, 10, 1'b0, -1);

        wait_drained();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_config(WINDOW_W'($urandom_range(1, 65535)), COUNT_W'($urandom_range(1, 254)));
        run_random(90, 10, 1'b0, 45);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (check_failures == 0 && results_pending == 0) begin
            $display("tb_per_source_rate_limiter_core OK");
        end else begin
            $display("tb_per_source_rate_limiter_core NOT OK");
        end
        $finish;
    end

endmodule
